@@ rtl/lap_pkg.sv @@
`default_nettype none
// ============================================================================
// lap_pkg: shared types and constants of the 3x3 Laplacian filter
// Field widths, register indexes, item codes and the line-store word layout.
// ============================================================================
package lap_pkg;

   localparam int PIXEL_W    = 8;
   localparam int SUM_W      = 11;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd512;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd512;
   localparam logic [PIXEL_W-1:0]  PIXEL_MAX    = 8'd255;

   // One line-store entry: the pixel two rows up and the pixel one row up.
   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] middle;
   } line_word_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] raw_sum;
      logic [PIXEL_W-1:0]      pixel_out;
      logic                    last;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/lap_if.sv @@
`default_nettype none
// ============================================================================
// lap_if: channel interfaces of the Laplacian filter
// Pixel input, result output and register write channels, valid/ready.
// ============================================================================
interface lap_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] pixel_in;

   modport source (output valid, output action, output pixel_in, input ready);
   modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface lap_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [10:0] raw_sum;
   logic [7:0]        pixel_out;
   logic              last;

   modport source (output valid, output raw_sum, output pixel_out, output last,
                   input ready);
   modport sink   (input valid, input raw_sum, input pixel_out, input last,
                   output ready);
endinterface

interface lap_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lap_line_store.sv @@
`default_nettype none
// ============================================================================
// lap_line_store: two-row line memory with column prefetch
// Holds the two previous rows as one word per column and keeps the words
// of the current and the following column ready for the next item.
// ============================================================================
module lap_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [ADDR_W-1:0]         col,
   input  wire logic [ADDR_W-1:0]         next_col,
   input  wire logic [ADDR_W-1:0]         after_col,
   input  wire logic [7:0]                pixel,
   output      lap_pkg::line_word_type    cur_word,
   output      logic [7:0]                next_middle
);
   import lap_pkg::*;

   line_word_type line_mem [DEPTH];

   line_word_type cur_ff, cur_in;
   line_word_type rd_data_ff;
   line_word_type fwd_data_ff;
   logic          fwd_ff;
   line_word_type next_word;
   line_word_type wr_word;

   // The word read one step ahead is replaced by the write that hit the
   // same column in that step.
   assign next_word = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_word   = '{upper: cur_ff.middle, middle: pixel};

   assign cur_word    = cur_ff;
   assign next_middle = next_word.middle;

   always_comb begin
      cur_in = (next_col == col) ? wr_word : next_word;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         line_mem[col] <= wr_word;
         rd_data_ff    <= line_mem[after_col];
         fwd_data_ff   <= wr_word;
         cur_ff        <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (step) begin
         fwd_ff <= (after_col == col);
      end
   end

endmodule
`default_nettype wire

@@ rtl/lap_out_buf.sv @@
`default_nettype none
// ============================================================================
// lap_out_buf: two-entry result buffer
// An output register plus a skid entry, so the input side keeps flowing
// while a result waits on the receiver.
// ============================================================================
module lap_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lap_pkg::rsp_type push_data,
   output      logic             can_push,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      lap_pkg::rsp_type out_data
);
   import lap_pkg::*;

   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_valid_ff && out_ready) begin
         main_valid_in = 1'b0;
      end
      if (!main_valid_in && skid_valid_ff) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!main_valid_in) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/laplacian_3x3_filter_unit.sv @@
`default_nettype none
// ============================================================================
// laplacian_3x3_filter_unit: streaming 3x3 four-neighbour Laplacian filter
// Raster-order 8-bit pixels in, signed and clamped Laplacian results out.
// ============================================================================
// Usage:
// Pixels enter on req_chan in raster order with action set to pixel. Each
// result is 4*centre minus the up, down, left and right neighbors, with zero
// outside the image, given as raw_sum and as pixel_out clamped to 0..255.
// The result for row r, column c leaves when the pixel of row r+1, column c
// is taken, so the first row yields no results. After the last image pixel
// the source sends one row of flush items; these push out the final row, and
// its last result carries last. Items of the wrong kind (a flush while image
// rows are due, a pixel while the flush row is due) are taken and dropped.
// One item is taken every clock while req_chan.ready is high. The line memory
// reads one word per item, two columns ahead of the current column, which
// sets that rate. When rsp_chan stalls, a result register and one skid entry
// fill before req_chan.ready drops. Writing image_width or image_height on
// csr_chan restarts the image; the port is always ready, and the user must
// write it only while the block is idle, which the block does not enforce.
// Reset returns to the start of an image with 512 x 512; the line memory is
// not cleared, since the first row of every image rewrites it before use.
// ============================================================================
module laplacian_3x3_filter_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input wire logic  clock,
   input wire logic  reset,
   lap_req_if.sink   req_chan,
   lap_rsp_if.source rsp_chan,
   lap_csr_if.sink   csr_chan
);
   import lap_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int RESET_COLS = (int'(RESET_WIDTH) > MAX_WIDTH) ? MAX_WIDTH
                                                               : int'(RESET_WIDTH);
   localparam logic [ADDR_W-1:0] RESET_LAST_COL = ADDR_W'(RESET_COLS - 1);
   localparam logic [ADDR_W-1:0] MAX_LAST_COL   = ADDR_W'(MAX_WIDTH - 1);

   // Geometry, held as the last column index and an effective height.
   logic [ADDR_W-1:0]   last_col_ff, last_col_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   // Raster position of the next item and the previous centre pixel.
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [PIXEL_W-1:0]  left_ff;

   logic                csr_write;
   logic [WIDTH_W-1:0]  csr_width;
   logic [HEIGHT_W-1:0] csr_height;

   logic                accept;
   logic                at_pad_row;
   logic                take;
   logic                emit;
   logic                row_end;
   logic [ADDR_W-1:0]   next_col;
   logic [ADDR_W-1:0]   after_col;

   line_word_type       cur_word;
   logic [PIXEL_W-1:0]  next_middle;
   logic [PIXEL_W-1:0]  pix_up, pix_centre, pix_left, pix_right, pix_down;
   logic signed [SUM_W:0] sum_wide;
   rsp_type             result;
   rsp_type             out_data;
   logic                can_push;

   // ------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_width      = csr_chan.data[WIDTH_W-1:0];
   assign csr_height     = csr_chan.data[HEIGHT_W-1:0];

   always_comb begin
      last_col_in = last_col_ff;
      height_in   = height_ff;
      if (csr_write && csr_chan.index == REG_IMAGE_WIDTH) begin
         if (csr_width == '0) begin
            last_col_in = '0;
         end else if ({21'd0, csr_width} > 32'(MAX_WIDTH)) begin
            last_col_in = MAX_LAST_COL;
         end else begin
            last_col_in = ADDR_W'(csr_width - WIDTH_W'(1));
         end
      end
      if (csr_write && csr_chan.index == REG_IMAGE_HEIGHT) begin
         height_in = (csr_height == '0) ? HEIGHT_W'(1) : csr_height;
      end
   end

   // ------------------------------------------------------------------
   // Item acceptance and raster position
   // ------------------------------------------------------------------
   assign req_chan.ready = can_push;
   assign accept         = req_chan.valid && req_chan.ready;
   assign at_pad_row     = (row_ff == height_ff);
   // An item counts only if its kind matches the row that is due.
   assign take           = accept && ((req_chan.action == ACT_FLUSH) == at_pad_row);
   assign emit           = take && (row_ff != '0);
   assign row_end        = (col_ff == last_col_ff);

   assign next_col  = row_end ? '0 : col_ff + ADDR_W'(1);
   assign after_col = (next_col == last_col_ff) ? '0 : next_col + ADDR_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write && (csr_chan.index == REG_IMAGE_WIDTH ||
                        csr_chan.index == REG_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         col_in = next_col;
         if (row_end) begin
            row_in = at_pad_row ? '0 : row_ff + HEIGHT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= RESET_LAST_COL;
         height_ff   <= RESET_HEIGHT;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         last_col_ff <= last_col_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         left_ff <= pix_centre;
      end
   end

   // ------------------------------------------------------------------
   // Line memory: rows r-2 and r-1 at the current and the next column
   // ------------------------------------------------------------------
   lap_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock       (clock),
      .reset       (reset),
      .step        (take),
      .col         (col_ff),
      .next_col    (next_col),
      .after_col   (after_col),
      .pixel       (pix_down),
      .cur_word    (cur_word),
      .next_middle (next_middle)
   );

   // ------------------------------------------------------------------
   // Kernel: neighbors outside the image read as zero
   // ------------------------------------------------------------------
   assign pix_down   = (req_chan.action == ACT_FLUSH) ? '0 : req_chan.pixel_in;
   assign pix_up     = (row_ff >= HEIGHT_W'(2)) ? cur_word.upper : '0;
   assign pix_centre = (row_ff != '0) ? cur_word.middle : '0;
   assign pix_left   = (col_ff != '0) ? left_ff : '0;
   assign pix_right  = (row_ff != '0 && !row_end) ? next_middle : '0;

   assign sum_wide = $signed({2'b00, pix_centre, 2'b00})
                   - $signed({4'b0000, pix_up})
                   - $signed({4'b0000, pix_down})
                   - $signed({4'b0000, pix_left})
                   - $signed({4'b0000, pix_right});

   always_comb begin
      result.raw_sum = sum_wide[SUM_W-1:0];
      if (sum_wide < 0) begin
         result.pixel_out = '0;
      end else if (sum_wide > $signed({4'b0000, PIXEL_MAX})) begin
         result.pixel_out = PIXEL_MAX;
      end else begin
         result.pixel_out = sum_wide[PIXEL_W-1:0];
      end
      result.last = at_pad_row && row_end;
   end

   // ------------------------------------------------------------------
   // Result buffer
   // ------------------------------------------------------------------
   lap_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .can_push  (can_push),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.raw_sum   = out_data.raw_sum;
   assign rsp_chan.pixel_out = out_data.pixel_out;
   assign rsp_chan.last      = out_data.last;

`ifndef SYNTH
   // The raster position never leaves the configured image plus pad row.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column position beyond the last column");

   a_row_in_image: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff)
      else $error("row position beyond the pad row");

   // After every emitted item the result channel holds a valid result the next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_chan.valid)
      else $error("emitted result not presented");

   // A marked last result is produced only in the pad row at its end.
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      (emit && result.last) |=> (col_ff == '0 && row_ff == '0))
      else $error("last result not followed by image restart");
`endif

endmodule
`default_nettype wire
